[rtl/core/spm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package spm_pkg;

  // input term fields
  localparam int unsigned COEF_W = 16;
  localparam int unsigned EXP_W  = 8;

  // result term fields
  localparam int unsigned RCOEF_W = 40;
  localparam int unsigned REXP_W  = 9;
  localparam int unsigned PROD_W  = 2 * COEF_W;

  // packed stream widths
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned OUT_TUSER_W = 2;

  // out_tuser bit positions
  localparam int unsigned TUSER_EMPTY   = 0;
  localparam int unsigned TUSER_DROPPED = 1;

  // in_tuser codes
  localparam logic ACT_FIRST  = 1'b0;
  localparam logic ACT_SECOND = 1'b1;

  // term stores
  localparam int unsigned STORE_DEPTH = 8;
  localparam int unsigned STORE_AW    = 3;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned TERM_W      = COEF_W + EXP_W;

  // merged result list
  localparam int unsigned MERGE_DEPTH = 64;
  localparam int unsigned MERGE_AW    = 6;
  localparam int unsigned MCNT_W      = 7;
  localparam int unsigned MERGE_W     = REXP_W + RCOEF_W;

  // exponent map: valid bit plus list index, one entry per result exponent
  localparam int unsigned MAP_DEPTH = 512;
  localparam int unsigned MAP_AW    = 9;
  localparam int unsigned MAP_W     = MERGE_AW + 1;

  typedef logic [RCOEF_W-1:0] rcoef_t;
  typedef logic [REXP_W-1:0]  rexp_t;

endpackage

`default_nettype wire

[rtl/core/spm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module spm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/sparse_poly_multiply.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sparse polynomial multiplier.
// Input stream: one term per request, in_tdata = {exp, coef}, in_tuser picks
// the first (0) or second (1) polynomial, in_tlast on a second-polynomial
// term starts the multiply. Up to MAX_TERMS terms per polynomial are kept;
// more are dropped and flagged in out_tuser.
// Multiply: every product pair, first outer and second inner, passes a store
// read, then a multiply and exponent map read; a new exponent is then written
// to the merged list RAM, while an existing result term gets one read-modify-write
// of the merged list RAM instead. Emit reads each result term from the merged
// list RAM and clears the exponent map entry behind it. An empty operand
// gives a single result flagged empty.
// in_tready is low from the starting term until the last result term is
// in the output register; a waiting output register stalls emission only.
// After reset a pass clears all 512 exponent map entries; in_tready stays low
// until it completes.
module sparse_poly_multiply #(
  parameter int MAX_TERMS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [15:0] term_coef, [23:16] term_exp
  input  wire logic [0:0]  in_tuser,   // [0] action
  input  wire logic        in_tlast,   // term_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [39:0] out_coef, [48:40] out_exp, rest zero
  output logic [1:0]       out_tuser,  // [0] out_empty, [1] out_dropped
  output logic             out_tlast   // out_last
);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_START   = 4'd2;
  localparam logic [3:0] S_RD      = 4'd3;
  localparam logic [3:0] S_MUL     = 4'd4;
  localparam logic [3:0] S_LOOK    = 4'd5;
  localparam logic [3:0] S_ACC     = 4'd6;
  localparam logic [3:0] S_EMIT_RD = 4'd7;
  localparam logic [3:0] S_EMIT_LD = 4'd8;

  localparam logic [spm_pkg::CNT_W-1:0] CNT_LIM = spm_pkg::CNT_W'(MAX_TERMS);

  logic [3:0]                     state_r, state_nxt;
  logic [spm_pkg::MAP_AW-1:0]     clr_r, clr_nxt;
  logic [spm_pkg::CNT_W-1:0]      fcnt_r, fcnt_nxt, scnt_r, scnt_nxt;
  logic                           drop_r, drop_nxt;
  logic [spm_pkg::STORE_AW-1:0]   i_r, i_nxt, j_r, j_nxt;
  logic [spm_pkg::MCNT_W-1:0]     mcnt_r, mcnt_nxt;
  logic [spm_pkg::MERGE_AW-1:0]   k_r, k_nxt, idx_r, idx_nxt;
  logic signed [spm_pkg::PROD_W-1:0] prod_r, prod_nxt;
  spm_pkg::rexp_t                 pexp_r, pexp_nxt;

  logic                           ovalid_r, ovalid_nxt;
  spm_pkg::rcoef_t                ocoef_r, ocoef_nxt;
  spm_pkg::rexp_t                 oexp_r, oexp_nxt;
  logic                           olast_r, olast_nxt;
  logic                           oempty_r, oempty_nxt;
  logic                           odrop_r, odrop_nxt;

  // store RAM ports
  logic                           f_we, s_we;
  logic [spm_pkg::TERM_W-1:0]     f_rdata, s_rdata, term_wdata;

  // exponent map RAM ports
  logic                           map_we;
  logic [spm_pkg::MAP_AW-1:0]     map_waddr;
  logic [spm_pkg::MAP_W-1:0]      map_wdata, map_rdata;
  spm_pkg::rexp_t                 exp_sum;

  // merged list RAM ports
  logic                           mrg_we;
  logic [spm_pkg::MERGE_AW-1:0]   mrg_waddr, mrg_raddr;
  logic [spm_pkg::MERGE_W-1:0]    mrg_wdata, mrg_rdata;

  logic signed [spm_pkg::COEF_W-1:0] a_coef, b_coef;
  spm_pkg::rcoef_t                prod_ext, acc_sum;
  logic                           accept, out_free, last_j, last_i, mlast;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !ovalid_r || out_tready;
  assign term_wdata = in_tdata;

  assign a_coef   = f_rdata[spm_pkg::COEF_W-1:0];
  assign b_coef   = s_rdata[spm_pkg::COEF_W-1:0];
  assign exp_sum  = spm_pkg::REXP_W'(f_rdata[spm_pkg::TERM_W-1:spm_pkg::COEF_W])
                  + spm_pkg::REXP_W'(s_rdata[spm_pkg::TERM_W-1:spm_pkg::COEF_W]);
  assign prod_ext = {{(spm_pkg::RCOEF_W - spm_pkg::PROD_W){prod_r[spm_pkg::PROD_W-1]}}, prod_r};
  assign acc_sum  = mrg_rdata[spm_pkg::RCOEF_W-1:0] + prod_ext;

  assign last_j = (spm_pkg::CNT_W'(j_r) + 1'b1) == scnt_r;
  assign last_i = (spm_pkg::CNT_W'(i_r) + 1'b1) == fcnt_r;
  assign mlast  = (spm_pkg::MCNT_W'(k_r) + 1'b1) == mcnt_r;

  assign f_we = accept && (in_tuser[0] == spm_pkg::ACT_FIRST) && (fcnt_r < CNT_LIM);
  assign s_we = accept && (in_tuser[0] == spm_pkg::ACT_SECOND) && (scnt_r < CNT_LIM);

  assign mrg_raddr = (state_r == S_LOOK) ? map_rdata[spm_pkg::MERGE_AW-1:0] : k_r;

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    fcnt_nxt   = fcnt_r;
    scnt_nxt   = scnt_r;
    drop_nxt   = drop_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    mcnt_nxt   = mcnt_r;
    k_nxt      = k_r;
    idx_nxt    = idx_r;
    prod_nxt   = prod_r;
    pexp_nxt   = pexp_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ocoef_nxt  = ocoef_r;
    oexp_nxt   = oexp_r;
    olast_nxt  = olast_r;
    oempty_nxt = oempty_r;
    odrop_nxt  = odrop_r;
    map_we     = 1'b0;
    map_waddr  = pexp_r;
    map_wdata  = '0;
    mrg_we     = 1'b0;
    mrg_waddr  = mcnt_r[spm_pkg::MERGE_AW-1:0];
    mrg_wdata  = {pexp_r, prod_ext};

    unique case (state_r)
      S_CLR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_tuser[0] == spm_pkg::ACT_FIRST) begin
            if (f_we) fcnt_nxt = fcnt_r + 1'b1;
            else      drop_nxt = 1'b1;
          end else begin
            if (s_we) scnt_nxt = scnt_r + 1'b1;
            else      drop_nxt = 1'b1;
            if (in_tlast) begin
              state_nxt = S_START;
            end
          end
        end
      end
      S_START: begin
        i_nxt    = '0;
        j_nxt    = '0;
        mcnt_nxt = '0;
        if (fcnt_r == '0 || scnt_r == '0) begin
          if (out_free) begin
            ovalid_nxt = 1'b1;
            ocoef_nxt  = '0;
            oexp_nxt   = '0;
            olast_nxt  = 1'b1;
            oempty_nxt = 1'b1;
            odrop_nxt  = drop_r;
            fcnt_nxt   = '0;
            scnt_nxt   = '0;
            drop_nxt   = 1'b0;
            state_nxt  = S_IDLE;
          end
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = a_coef * b_coef;
        pexp_nxt  = exp_sum;
        state_nxt = S_LOOK;
      end
      S_LOOK, S_ACC: begin
        if (state_r == S_LOOK && map_rdata[spm_pkg::MAP_W-1]) begin
          // exponent seen before: fetch its running sum
          idx_nxt   = map_rdata[spm_pkg::MERGE_AW-1:0];
          state_nxt = S_ACC;
        end else begin
          mrg_we = 1'b1;
          if (state_r == S_ACC) begin
            mrg_waddr = idx_r;
            mrg_wdata = {pexp_r, acc_sum};
          end else begin
            map_we    = 1'b1;
            map_wdata = {1'b1, mcnt_r[spm_pkg::MERGE_AW-1:0]};
            mcnt_nxt  = mcnt_r + 1'b1;
          end
          state_nxt = S_RD;
          if (last_j) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
            if (last_i) begin
              k_nxt     = '0;
              state_nxt = S_EMIT_RD;
            end
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      S_EMIT_RD: begin
        if (out_free) begin
          state_nxt = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        ovalid_nxt = 1'b1;
        ocoef_nxt  = mrg_rdata[spm_pkg::RCOEF_W-1:0];
        oexp_nxt   = mrg_rdata[spm_pkg::MERGE_W-1:spm_pkg::RCOEF_W];
        olast_nxt  = mlast;
        oempty_nxt = 1'b0;
        odrop_nxt  = drop_r;
        // leave the exponent map clean for the next run
        map_we     = 1'b1;
        map_waddr  = mrg_rdata[spm_pkg::MERGE_W-1:spm_pkg::RCOEF_W];
        k_nxt      = k_r + 1'b1;
        if (mlast) begin
          fcnt_nxt  = '0;
          scnt_nxt  = '0;
          drop_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      fcnt_r   <= '0;
      scnt_r   <= '0;
      drop_r   <= 1'b0;
      mcnt_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      fcnt_r   <= fcnt_nxt;
      scnt_r   <= scnt_nxt;
      drop_r   <= drop_nxt;
      mcnt_r   <= mcnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    idx_r    <= idx_nxt;
    prod_r   <= prod_nxt;
    pexp_r   <= pexp_nxt;
    ocoef_r  <= ocoef_nxt;
    oexp_r   <= oexp_nxt;
    olast_r  <= olast_nxt;
    oempty_r <= oempty_nxt;
    odrop_r  <= odrop_nxt;
  end

  spm_ram #(.WIDTH(spm_pkg::TERM_W), .DEPTH(spm_pkg::STORE_DEPTH)) u_first_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (fcnt_r[spm_pkg::STORE_AW-1:0]),
    .wdata (term_wdata),
    .raddr (i_r),
    .rdata (f_rdata)
  );

  spm_ram #(.WIDTH(spm_pkg::TERM_W), .DEPTH(spm_pkg::STORE_DEPTH)) u_second_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (scnt_r[spm_pkg::STORE_AW-1:0]),
    .wdata (term_wdata),
    .raddr (j_r),
    .rdata (s_rdata)
  );

  spm_ram #(.WIDTH(spm_pkg::MAP_W), .DEPTH(spm_pkg::MAP_DEPTH)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (exp_sum),
    .rdata (map_rdata)
  );

  spm_ram #(.WIDTH(spm_pkg::MERGE_W), .DEPTH(spm_pkg::MERGE_DEPTH)) u_merge_ram (
    .clk   (clk),
    .we    (mrg_we),
    .waddr (mrg_waddr),
    .wdata (mrg_wdata),
    .raddr (mrg_raddr),
    .rdata (mrg_rdata)
  );

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {(spm_pkg::OUT_TDATA_W - spm_pkg::MERGE_W)'(0), oexp_r, ocoef_r};
  assign out_tuser  = {odrop_r, oempty_r};
  assign out_tlast  = olast_r;

endmodule

`default_nettype wire

[rtl/core/spm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module spm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [0:0]  in_tuser,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // no loads are taken while a result list is still being emitted
  a_emit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("load accepted mid result list");

  // the multiply request closes the input side at once
  a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == spm_pkg::ACT_SECOND) && in_tlast
      |=> !in_tready)
    else $error("input open after multiply request");

  // an empty result is a single zero term
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[spm_pkg::TUSER_EMPTY] |-> out_tlast && (out_tdata == '0))
    else $error("malformed empty result");

endmodule

bind sparse_poly_multiply spm_checker u_spm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int TERM_LIMIT     = 8;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS   = 140;

  typedef struct {
    logic                              act;
    logic signed [spm_pkg::COEF_W-1:0] coef;
    logic [spm_pkg::EXP_W-1:0]         expo;
    logic                              last;
    bit                                wait_idle;  // hold this request back until nothing is pending
  } term_req_t;

  typedef struct {
    spm_pkg::rcoef_t coef;
    spm_pkg::rexp_t  expo;
    logic            last;
    logic            empty;
    logic            dropped;
  } prod_term_t;

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [spm_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;  // [15:0] term_coef, [23:16] term_exp
  logic [0:0]                      in_tuser   = '0;  // [0] action
  logic                            in_tlast   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [spm_pkg::OUT_TDATA_W-1:0] out_tdata;        // [39:0] out_coef, [48:40] out_exp
  logic [spm_pkg::OUT_TUSER_W-1:0] out_tuser;        // [0] out_empty, [1] out_dropped
  logic                            out_tlast;

  term_req_t  term_queue[$];
  prod_term_t expected_terms[$];
  term_req_t  on_bus;
  prod_term_t want;

  // shadow copy of the two term stores
  logic signed [spm_pkg::COEF_W-1:0] lhs_coef[spm_pkg::STORE_DEPTH];
  logic [spm_pkg::EXP_W-1:0]         lhs_expo[spm_pkg::STORE_DEPTH];
  logic signed [spm_pkg::COEF_W-1:0] rhs_coef[spm_pkg::STORE_DEPTH];
  logic [spm_pkg::EXP_W-1:0]         rhs_expo[spm_pkg::STORE_DEPTH];
  int lhs_n = 0;
  int rhs_n = 0;
  bit drop_seen = 1'b0;

  int sent_n = 0;
  int got_n = 0;
  int fails = 0;
  int rx_hold_left = 0;
  bit rx_hold_done = 1'b0;

  sparse_poly_multiply #(
    .MAX_TERMS(TERM_LIMIT)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Load one term; the closing term of the second polynomial forms all products,
  // merges equal exponents in order of first appearance and queues the result list.
  task automatic absorb_term(input term_req_t t);
    longint         sums[spm_pkg::MERGE_DEPTH];
    spm_pkg::rexp_t keys[spm_pkg::MERGE_DEPTH];
    int             n_keys;
    longint         prod;
    spm_pkg::rexp_t e;
    bit             found;
    prod_term_t     r;
    if (t.act == spm_pkg::ACT_FIRST) begin
      if (lhs_n < TERM_LIMIT) begin
        lhs_coef[lhs_n] = t.coef;
        lhs_expo[lhs_n] = t.expo;
        lhs_n++;
      end else begin
        drop_seen = 1'b1;
      end
      return;
    end
    if (rhs_n < TERM_LIMIT) begin
      rhs_coef[rhs_n] = t.coef;
      rhs_expo[rhs_n] = t.expo;
      rhs_n++;
    end else begin
      drop_seen = 1'b1;
    end
    if (!t.last) return;

    if (lhs_n == 0 || rhs_n == 0) begin
      r.coef    = '0;
      r.expo    = '0;
      r.last    = 1'b1;
      r.empty   = 1'b1;
      r.dropped = drop_seen;
      expected_terms.push_back(r);
    end else begin
      n_keys = 0;
      for (int i = 0; i < lhs_n; i++) begin
        for (int j = 0; j < rhs_n; j++) begin
          prod  = longint'(lhs_coef[i]) * longint'(rhs_coef[j]);
          e     = {1'b0, lhs_expo[i]} + {1'b0, rhs_expo[j]};
          found = 1'b0;
          for (int k = 0; k < n_keys; k++) begin
            if (keys[k] == e) begin
              sums[k] += prod;
              found = 1'b1;
            end
          end
          if (!found) begin
            keys[n_keys] = e;
            sums[n_keys] = prod;
            n_keys++;
          end
        end
      end
      for (int k = 0; k < n_keys; k++) begin
        r.coef    = sums[k][spm_pkg::RCOEF_W-1:0];
        r.expo    = keys[k];
        r.last    = (k == n_keys - 1);
        r.empty   = 1'b0;
        r.dropped = drop_seen;
        expected_terms.push_back(r);
      end
    end
    lhs_n     = 0;
    rhs_n     = 0;
    drop_seen = 1'b0;
  endtask

  task automatic add_term(input logic act, input logic [spm_pkg::COEF_W-1:0] coef,
                          input logic [spm_pkg::EXP_W-1:0] expo, input logic last,
                          input bit wait_idle);
    term_req_t t;
    t.act       = act;
    t.coef      = coef;
    t.expo      = expo;
    t.last      = last;
    t.wait_idle = wait_idle;
    term_queue.push_back(t);
  endtask

  function automatic logic [spm_pkg::COEF_W-1:0] pick_coef();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 14) return 16'h7fff;
    if (r < 20) return 16'h8000;
    return spm_pkg::COEF_W'($urandom_range(65535));
  endfunction

  // a narrow pool of exponents makes merging common
  function automatic logic [spm_pkg::EXP_W-1:0] pick_expo();
    int r;
    r = $urandom_range(99);
    if (r < 45) return spm_pkg::EXP_W'($urandom_range(7));
    if (r < 50) return 8'hff;
    return spm_pkg::EXP_W'($urandom_range(255));
  endfunction

  // One multiply: first-polynomial terms mixed in among the second's, which closes it.
  // Sizes past the store limit give dropped terms; no first terms gives an empty result.
  task automatic add_random_set(input bit wait_idle);
    int na;
    int nb;
    int ia;
    int ib;
    int r;
    bit hold;
    r  = $urandom_range(99);
    na = (r < 10) ? 0 : (r < 20) ? $urandom_range(10, 9) : $urandom_range(8, 1);
    r  = $urandom_range(99);
    nb = (r < 12) ? $urandom_range(10, 9) : $urandom_range(8, 1);
    ia = 0;
    ib = 0;
    hold = wait_idle;
    while (ia < na || ib < nb - 1) begin
      if (ia < na && (ib >= nb - 1 || $urandom_range(1) == 1)) begin
        // last mark on the first polynomial only loads the term
        add_term(spm_pkg::ACT_FIRST, pick_coef(), pick_expo(), $urandom_range(99) < 15,
                 hold);
        ia++;
      end else begin
        add_term(spm_pkg::ACT_SECOND, pick_coef(), pick_expo(), 1'b0, hold);
        ib++;
      end
      hold = 1'b0;
    end
    add_term(spm_pkg::ACT_SECOND, pick_coef(), pick_expo(), 1'b1, hold);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_term(on_bus);
        sent_n++;
      end
      if (!in_tvalid || in_tready) begin
        if (term_queue.size() > 0
            && ((sent_n >= 70 && sent_n < 110) || $urandom_range(99) >= 6)
            && !(term_queue[0].wait_idle && expected_terms.size() > 0)) begin
          on_bus = term_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {on_bus.expo, on_bus.coef};
          in_tuser  <= on_bus.act;
          in_tlast  <= on_bus.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, a calm stretch and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_tready   <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (!rx_hold_done && got_n >= 30) begin
      rx_hold_done <= 1'b1;
      rx_hold_left <= RX_HOLD_CYCLES;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= (got_n >= 80 && got_n < 200) || ($urandom_range(99) >= 6);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_n <= got_n + 1;
      if (expected_terms.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("ERROR: result with nothing pending: coef=%0d exp=%0d last=%b tuser=%b",
                   $signed(out_tdata[spm_pkg::RCOEF_W-1:0]),
                   out_tdata[spm_pkg::RCOEF_W +: spm_pkg::REXP_W], out_tlast, out_tuser);
      end else begin
        want = expected_terms.pop_front();
        if (out_tdata[spm_pkg::RCOEF_W-1:0] !== want.coef
            || out_tdata[spm_pkg::RCOEF_W +: spm_pkg::REXP_W] !== want.expo
            || out_tlast !== want.last
            || out_tuser[spm_pkg::TUSER_EMPTY] !== want.empty
            || out_tuser[spm_pkg::TUSER_DROPPED] !== want.dropped) begin
          fails++;
          if (fails <= 10) begin
            $display("ERROR: result %0d expected coef=%0d exp=%0d last=%b empty=%b dropped=%b",
                     got_n, $signed(want.coef), want.expo, want.last, want.empty,
                     want.dropped);
            $display("       got      coef=%0d exp=%0d last=%b empty=%b dropped=%b",
                     $signed(out_tdata[spm_pkg::RCOEF_W-1:0]),
                     out_tdata[spm_pkg::RCOEF_W +: spm_pkg::REXP_W], out_tlast,
                     out_tuser[spm_pkg::TUSER_EMPTY], out_tuser[spm_pkg::TUSER_DROPPED]);
          end
        end
      end
    end
  end

  initial begin
    // empty first operand
    add_term(spm_pkg::ACT_SECOND, 16'h1234, 8'd9, 1'b1, 1'b0);
    // extremes of coefficient and exponent, last mark on the first polynomial
    add_term(spm_pkg::ACT_FIRST, 16'h7fff, 8'hff, 1'b1, 1'b0);
    add_term(spm_pkg::ACT_FIRST, 16'h8000, 8'h00, 1'b0, 1'b0);
    add_term(spm_pkg::ACT_SECOND, 16'h8000, 8'hff, 1'b0, 1'b0);
    add_term(spm_pkg::ACT_SECOND, 16'h7fff, 8'h00, 1'b1, 1'b0);
    // interleaved loads, middle term cancels to zero
    add_term(spm_pkg::ACT_SECOND, 16'd1, 8'd2, 1'b0, 1'b0);
    add_term(spm_pkg::ACT_FIRST, 16'd1, 8'd1, 1'b0, 1'b0);
    add_term(spm_pkg::ACT_FIRST, 16'd1, 8'd2, 1'b0, 1'b0);
    add_term(spm_pkg::ACT_SECOND, 16'hffff, 8'd3, 1'b1, 1'b0);
    // first store overfills by one; includes a zero coefficient
    for (int i = 0; i < TERM_LIMIT + 1; i++)
      add_term(spm_pkg::ACT_FIRST, spm_pkg::COEF_W'(i - 4), spm_pkg::EXP_W'(i * 3),
               1'b0, 1'b0);
    add_term(spm_pkg::ACT_SECOND, 16'd2, 8'd7, 1'b1, 1'b0);

    for (int s = 0; term_queue.size() < 19 + RANDOM_ITEMS; s++)
      add_random_set(s == 6);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (term_queue.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_terms.size() > 0) @(posedge clk);
    repeat (600) @(posedge clk);

    if (fails == 0 && expected_terms.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sparse_poly_multiply.f]
rtl/core/spm_pkg.sv
rtl/core/spm_ram.sv
rtl/core/sparse_poly_multiply.sv
rtl/core/spm_checker.sv
bench/tb.sv
